[rtl/mbet_pkg.sv]
// Shared types and constants for the Mandelbrot escape-time block.
// Payload structs for the pixel, result and register write channels.
// No dependencies.
package mbet_pkg;

  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_CENTER_REAL = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_IMAG = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_STEP  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PALETTE     = 3'd4;

  localparam logic signed [31:0] CENTER_RESET = 32'sd0;
  localparam logic [30:0]        STEP_RESET   = 31'd1048576;
  localparam logic [20:0]        MAX_RESET    = 21'd96;
  localparam logic [12:0]        PAL_RESET    = 13'd512;

  // |z|^2 > 4 in Q8.56
  localparam logic [63:0] ESCAPE_SQ = 64'd4 << (2 * FRAC_BITS);

  typedef struct packed {
    logic signed [11:0] x_offset;
    logic signed [11:0] y_offset;
  } pix_t;

  typedef struct packed {
    logic        escaped;
    logic [20:0] iterations;
    logic [11:0] color_index;
  } res_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] idx;
    logic [31:0]          wdata;
  } cfg_t;

endpackage

[rtl/mbet_chan_if.sv]
// Valid/ready channel carrying one payload of type T per beat.
// Used for the pixel, result and register write channels; no dependencies.
interface mbet_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/mbet_mul.sv]
// Shared signed 32x32 multiplier with a registered 64-bit product.
// No dependencies; used by mandelbrot_escape_time.
module mbet_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

[rtl/mandelbrot_escape_time.sv]
// Mandelbrot escape-time evaluator for one pixel per beat.
// Depends on mbet_pkg, mbet_chan_if and mbet_mul.
//
//   channel  dir  payload                               handshake
//   pix_i    in   x_offset, y_offset                    valid/ready
//   cfg_i    in   idx, wdata (register write)           valid/ready, always ready
//   res_o    out  escaped, iterations, color_index      valid/ready
//
// A pixel passes S_MCX, S_MCY and S_CYW, then S_UPD, S_MXX, S_MYY and S_MAG per
// iteration, then S_FIN; the single shared multiplier does three products per
// iteration. A zero limit skips to S_FIN. pix_i is ready only while no pixel
// is in work. A finished result waits in the output register; a later result
// waits until it is taken. Reset loads the register defaults; no clearing pass.
module mandelbrot_escape_time #(
  parameter int HALF_SPAN = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbet_chan_if.sink   pix_i,
  mbet_chan_if.sink   cfg_i,
  mbet_chan_if.source res_o
);

  localparam int OFS_W = ($clog2(HALF_SPAN) + 1 > 12) ? $clog2(HALF_SPAN) + 1 : 12;
  localparam int CMP_W = OFS_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MCX, S_MCY, S_CYW, S_UPD, S_MXX, S_MYY, S_MAG, S_FIN
  } state_e;

  function automatic logic signed [31:0] sat_q(logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [OFS_W-1:0] clamp_ofs(logic signed [11:0] v);
    logic signed [CMP_W-1:0] w;
    logic signed [CMP_W-1:0] lo;
    logic signed [CMP_W-1:0] hi;
    w  = CMP_W'(v);
    lo = -(CMP_W'(HALF_SPAN));
    hi = CMP_W'(HALF_SPAN - 1);
    if (w < lo) begin
      w = lo;
    end else if (w > hi) begin
      w = hi;
    end
    return w[OFS_W-1:0];
  endfunction

  state_e state_q;

  logic signed [31:0] center_re_q, center_im_q;
  logic [30:0]        step_q;
  logic [20:0]        max_q;
  logic [12:0]        pal_q;

  logic signed [OFS_W-1:0] xo_q, yo_q;
  logic signed [31:0]      cx_q, cy_q, zx_q, zy_q;
  logic signed [63:0]      sxx_q, syy_q;
  logic [20:0]             n_q;
  logic [12:0]             m_q;
  mbet_pkg::res_t          res_q, out_q;
  logic                    out_valid_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] nx, ny;
  logic [63:0]        mag;
  logic               last_iter;
  logic [13:0]        m_inc;
  logic               out_free;

  mbet_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    unique case (state_q)
      S_MCX: begin
        mul_a = 32'(xo_q);
        mul_b = signed'({1'b0, step_q});
      end
      S_MCY: begin
        mul_a = 32'(yo_q);
        mul_b = signed'({1'b0, step_q});
      end
      S_MXX: begin
        mul_a = zx_q;
        mul_b = zx_q;
      end
      S_MYY: begin
        mul_a = zy_q;
        mul_b = zy_q;
      end
      default: begin
        mul_a = zx_q;
        mul_b = zy_q;
      end
    endcase
  end

  assign nx        = ((sxx_q - syy_q) >>> mbet_pkg::FRAC_BITS) - 64'(cx_q);
  assign ny        = (prod >>> (mbet_pkg::FRAC_BITS - 1)) - 64'(cy_q);
  assign mag       = $unsigned(sxx_q) + $unsigned(prod);
  assign last_iter = ({1'b0, n_q} + 22'd1) == {1'b0, max_q};
  assign m_inc     = {1'b0, m_q} + 14'd1;
  assign out_free  = !out_valid_q || res_o.ready;

  assign pix_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      center_re_q <= mbet_pkg::CENTER_RESET;
      center_im_q <= mbet_pkg::CENTER_RESET;
      step_q      <= mbet_pkg::STEP_RESET;
      max_q       <= mbet_pkg::MAX_RESET;
      pal_q       <= mbet_pkg::PAL_RESET;
      xo_q        <= '0;
      yo_q        <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      zx_q        <= '0;
      zy_q        <= '0;
      sxx_q       <= '0;
      syy_q       <= '0;
      n_q         <= '0;
      m_q         <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.data.idx)
          mbet_pkg::REG_CENTER_REAL: center_re_q <= signed'(cfg_i.data.wdata);
          mbet_pkg::REG_CENTER_IMAG: center_im_q <= signed'(cfg_i.data.wdata);
          mbet_pkg::REG_PIXEL_STEP:  step_q      <= cfg_i.data.wdata[30:0];
          mbet_pkg::REG_MAX_ITER:    max_q       <= cfg_i.data.wdata[20:0];
          mbet_pkg::REG_PALETTE:     pal_q       <= cfg_i.data.wdata[12:0];
          default: ;
        endcase
      end

      if (out_valid_q && res_o.ready && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (pix_i.valid) begin
            xo_q  <= clamp_ofs(pix_i.data.x_offset);
            yo_q  <= clamp_ofs(pix_i.data.y_offset);
            zx_q  <= '0;
            zy_q  <= '0;
            sxx_q <= '0;
            syy_q <= '0;
            n_q   <= '0;
            m_q   <= '0;
            res_q <= '0;
            if (max_q == '0) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_MCX;
            end
          end
        end
        S_MCX: state_q <= S_MCY;
        S_MCY: begin
          cx_q    <= sat_q(64'(center_re_q) + prod);
          state_q <= S_CYW;
        end
        S_CYW: begin
          cy_q    <= sat_q(64'(center_im_q) + prod);
          state_q <= S_UPD;
        end
        S_UPD: begin
          zx_q    <= sat_q(nx);
          zy_q    <= sat_q(ny);
          state_q <= S_MXX;
        end
        S_MXX: state_q <= S_MYY;
        S_MYY: begin
          sxx_q   <= prod;
          state_q <= S_MAG;
        end
        S_MAG: begin
          syy_q <= prod;
          if (mag > mbet_pkg::ESCAPE_SQ) begin
            res_q.escaped     <= 1'b1;
            res_q.iterations  <= n_q;
            res_q.color_index <= (pal_q != '0) ? m_q[11:0] : 12'd0;
            state_q           <= S_FIN;
          end else if (last_iter) begin
            res_q.escaped     <= 1'b0;
            res_q.iterations  <= max_q;
            res_q.color_index <= 12'd0;
            state_q           <= S_FIN;
          end else begin
            n_q     <= n_q + 21'd1;
            m_q     <= (m_inc == {1'b0, pal_q}) ? 13'd0 : m_inc[12:0];
            state_q <= S_UPD;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
